// ===== rtl/core/pbd_pkg.sv =====
`default_nettype none
package pbd_pkg;

	localparam int STIFF_W = 17;
	localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;

	localparam int ADDR_W = 3;
	localparam logic REG_STIFFNESS = 1'b0;

	localparam logic [1:0] STATUS_APPLIED   = 2'd0;
	localparam logic [1:0] STATUS_SKIP_MASS = 2'd1;
	localparam logic [1:0] STATUS_SKIP_LEN  = 2'd2;

	// saturate a magnitude with a sign to 32-bit two's complement
	function automatic logic [31:0] sat32(input logic [34:0] mag, input logic neg);
		logic [34:0] m;
		begin
			m = mag;
			if (neg) begin
				if (m > 35'h080000000) m = 35'h080000000;
				sat32 = 32'(35'd0 - m);
			end else begin
				if (m > 35'h07FFFFFFF) m = 35'h07FFFFFFF;
				sat32 = m[31:0];
			end
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pbd_apb_regs.sv =====
`default_nettype none
module pbd_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pbd_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output logic      [pbd_pkg::STIFF_W-1:0]   stiffness
);

	logic [pbd_pkg::STIFF_W-1:0] stiff_q;
	logic                        wr_en;

	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;
	assign stiffness = stiff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= pbd_pkg::STIFF_RESET;
		end else if (wr_en && paddr[2] == pbd_pkg::REG_STIFFNESS) begin
			stiff_q <= pwdata[pbd_pkg::STIFF_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == pbd_pkg::REG_STIFFNESS) begin
			prdata = 32'(stiff_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pbd_distance_constraint_projection_unit.sv =====
// Throughput: one edge per cycle unless out_ready back-pressure stalls the pipeline;
// every stage has its own valid bit and fills bubbles.
// Depth is set by the 34-step square-root pipeline and the FRAC_BITS+1 step divider.
// Reset: arst_n clears all valid bits and loads stiffness with 1.0; data needs no reset.
`default_nettype none
module pbd_distance_constraint_projection_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pbd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [31:0]          pos_a_x,
	input  wire logic signed [31:0]          pos_a_y,
	input  wire logic signed [31:0]          pos_a_z,
	input  wire logic signed [31:0]          pos_b_x,
	input  wire logic signed [31:0]          pos_b_y,
	input  wire logic signed [31:0]          pos_b_z,
	input  wire logic [23:0]                 inv_mass_a,
	input  wire logic [23:0]                 inv_mass_b,
	input  wire logic [30:0]                 rest_length,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [31:0]               delta_a_x,
	output logic signed [31:0]               delta_a_y,
	output logic signed [31:0]               delta_a_z,
	output logic signed [31:0]               delta_b_x,
	output logic signed [31:0]               delta_b_y,
	output logic signed [31:0]               delta_b_z,
	output logic [1:0]                       result_status
);

	localparam int DW  = 33 + FRAC_BITS;
	localparam int DSW = 35 + FRAC_BITS;
	localparam int PW  = 35 + FRAC_BITS;

	localparam int ST_SQ  = 2;
	localparam int ST_SUM = 3;
	localparam int ST_RT0 = 4;
	localparam int ST_EM  = ST_RT0 + 34;
	localparam int ST_DV0 = ST_EM + 1;
	localparam int ST_MU  = ST_DV0 + FRAC_BITS + 1;
	localparam int ST_MF  = ST_MU + 1;
	localparam int NST    = ST_MF + 1;

	typedef struct packed {
		logic [2:0][32:0]       mag;
		logic [2:0]             dneg;
		logic [2:0][65:0]       sq;
		logic [66:0]            rem;
		logic [33:0]            root;
		logic [40:0]            num_a;
		logic [40:0]            num_b;
		logic [24:0]            wsum;
		logic [16:0]            fa;
		logic [16:0]            fb;
		logic [30:0]            rest;
		logic [33:0]            emag;
		logic                   eneg;
		logic [1:0]             status;
		logic [2:0][DW-1:0]     dnum;
		logic [2:0][FRAC_BITS:0] u;
		logic [2:0][33:0]       c;
		logic [2:0][34:0]       ma;
		logic [2:0][34:0]       mb;
		logic [2:0][31:0]       da;
		logic [2:0][31:0]       db;
	} item_t;

	logic [pbd_pkg::STIFF_W-1:0] stiffness;

	item_t          data_s [1:NST];
	item_t          nxt    [1:NST];
	logic [NST:1]   vld_s;
	logic [NST:1]   adv;

	pbd_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.stiffness (stiffness)
	);

	// entry: differences, mass products, inverse-mass sum
	always_comb begin
		logic [2:0][31:0] pa;
		logic [2:0][31:0] pb;
		logic [32:0]      d;
		nxt[1] = '0;
		pa = {pos_a_z, pos_a_y, pos_a_x};
		pb = {pos_b_z, pos_b_y, pos_b_x};
		for (int i = 0; i < 3; i++) begin
			d = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
			nxt[1].dneg[i] = d[32];
			nxt[1].mag[i]  = d[32] ? 33'd0 - d : d;
		end
		nxt[1].num_a = 41'(inv_mass_a) * 41'(stiffness);
		nxt[1].num_b = 41'(inv_mass_b) * 41'(stiffness);
		nxt[1].wsum  = 25'(inv_mass_a) + 25'(inv_mass_b);
		nxt[1].rest  = rest_length;
	end

	for (genvar k = 2; k <= NST; k++) begin : g_st
		if (k == ST_SQ) begin : g_sq
			always_comb begin
				nxt[k] = data_s[k-1];
				for (int i = 0; i < 3; i++) begin
					nxt[k].sq[i] = 66'(data_s[k-1].mag[i]) * 66'(data_s[k-1].mag[i]);
				end
			end
		end else if (k == ST_SUM) begin : g_sum
			always_comb begin
				nxt[k] = data_s[k-1];
				nxt[k].rem  = 67'(data_s[k-1].sq[0]) + 67'(data_s[k-1].sq[1])
					+ 67'(data_s[k-1].sq[2]);
				nxt[k].root = '0;
				nxt[k].fa   = '0;
				nxt[k].fb   = '0;
			end
		end else if (k < ST_EM) begin : g_rt
			localparam int RB   = 33 - (k - ST_RT0);
			localparam bit DO_M = (k - ST_RT0) <= 16;
			localparam int MB   = DO_M ? 16 - (k - ST_RT0) : 0;
			always_comb begin
				logic [67:0] t;
				logic [41:0] ds;
				nxt[k] = data_s[k-1];
				t = (68'(data_s[k-1].root) << (RB + 1)) + (68'd1 << (2 * RB));
				if (68'(data_s[k-1].rem) >= t) begin
					nxt[k].rem      = 67'(68'(data_s[k-1].rem) - t);
					nxt[k].root[RB] = 1'b1;
				end
				ds = 42'(data_s[k-1].wsum) << MB;
				if (DO_M) begin
					if (42'(data_s[k-1].num_a) >= ds) begin
						nxt[k].num_a  = 41'(42'(data_s[k-1].num_a) - ds);
						nxt[k].fa[MB] = 1'b1;
					end
					if (42'(data_s[k-1].num_b) >= ds) begin
						nxt[k].num_b  = 41'(42'(data_s[k-1].num_b) - ds);
						nxt[k].fb[MB] = 1'b1;
					end
				end
			end
		end else if (k == ST_EM) begin : g_em
			always_comb begin
				nxt[k] = data_s[k-1];
				if (data_s[k-1].wsum == '0) begin
					nxt[k].status = pbd_pkg::STATUS_SKIP_MASS;
				end else if (data_s[k-1].root == '0) begin
					nxt[k].status = pbd_pkg::STATUS_SKIP_LEN;
				end else begin
					nxt[k].status = pbd_pkg::STATUS_APPLIED;
				end
				nxt[k].eneg = data_s[k-1].root < 34'(data_s[k-1].rest);
				nxt[k].emag = nxt[k].eneg ? 34'(data_s[k-1].rest) - data_s[k-1].root
					: data_s[k-1].root - 34'(data_s[k-1].rest);
				for (int i = 0; i < 3; i++) begin
					nxt[k].dnum[i] = DW'(data_s[k-1].mag[i]) << FRAC_BITS;
				end
				nxt[k].u = '0;
			end
		end else if (k < ST_MU) begin : g_dv
			localparam int UB = FRAC_BITS - (k - ST_DV0);
			always_comb begin
				logic [DSW-1:0] ds;
				nxt[k] = data_s[k-1];
				ds = DSW'(data_s[k-1].root) << UB;
				for (int i = 0; i < 3; i++) begin
					if (DSW'(data_s[k-1].dnum[i]) >= ds) begin
						nxt[k].dnum[i]  = DW'(DSW'(data_s[k-1].dnum[i]) - ds);
						nxt[k].u[i][UB] = 1'b1;
					end
				end
			end
		end else if (k == ST_MU) begin : g_mu
			always_comb begin
				logic [PW-1:0] p;
				nxt[k] = data_s[k-1];
				for (int i = 0; i < 3; i++) begin
					p = PW'(data_s[k-1].emag) * PW'(data_s[k-1].u[i]);
					nxt[k].c[i] = 34'(p >> FRAC_BITS);
				end
			end
		end else if (k == ST_MF) begin : g_mf
			always_comb begin
				logic [50:0] pa;
				logic [50:0] pb;
				nxt[k] = data_s[k-1];
				for (int i = 0; i < 3; i++) begin
					pa = 51'(data_s[k-1].c[i]) * 51'(data_s[k-1].fa);
					pb = 51'(data_s[k-1].c[i]) * 51'(data_s[k-1].fb);
					nxt[k].ma[i] = 35'(pa >> 16);
					nxt[k].mb[i] = 35'(pb >> 16);
				end
			end
		end else begin : g_out
			always_comb begin
				logic pn;
				nxt[k] = data_s[k-1];
				for (int i = 0; i < 3; i++) begin
					pn = data_s[k-1].eneg != data_s[k-1].dneg[i];
					if (data_s[k-1].status == pbd_pkg::STATUS_APPLIED) begin
						nxt[k].da[i] = pbd_pkg::sat32(data_s[k-1].ma[i], !pn);
						nxt[k].db[i] = pbd_pkg::sat32(data_s[k-1].mb[i], pn);
					end else begin
						nxt[k].da[i] = '0;
						nxt[k].db[i] = '0;
					end
				end
			end
		end
	end

	// per-stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		adv[NST] = !vld_s[NST] || out_ready;
		for (int k = NST - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= NST; k++) begin
				if (adv[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NST; k++) begin
			if (adv[k]) data_s[k] <= nxt[k];
		end
	end

	assign out_valid     = vld_s[NST];
	assign delta_a_x     = data_s[NST].da[0];
	assign delta_a_y     = data_s[NST].da[1];
	assign delta_a_z     = data_s[NST].da[2];
	assign delta_b_x     = data_s[NST].db[0];
	assign delta_b_y     = data_s[NST].db[1];
	assign delta_b_z     = data_s[NST].db[2];
	assign result_status = data_s[NST].status;

`ifndef SYNTH
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status != pbd_pkg::STATUS_APPLIED |->
			delta_a_x == 0 && delta_a_y == 0 && delta_a_z == 0 &&
			delta_b_x == 0 && delta_b_y == 0 && delta_b_z == 0)
		else $error("skipped edge carries nonzero correction");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	a_opposite_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(delta_a_x > 0 && delta_b_x > 0) && !(delta_a_x < 0 && delta_b_x < 0))
		else $error("endpoint corrections point the same way");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_status == pbd_pkg::STATUS_APPLIED ||
			result_status == pbd_pkg::STATUS_SKIP_MASS ||
			result_status == pbd_pkg::STATUS_SKIP_LEN)
		else $error("undefined status code");
`endif

endmodule
`default_nettype wire
